[src/fpc_pkg.sv]
// ----------------------------------------------------------------------------
// Fuzzy priority controller package
// Shared types, constants and membership functions.
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned OUT_POINTS = 21;
  localparam int unsigned DIV_STEPS  = 12;
  localparam logic [15:0] DEG_ONE    = 16'h8000;
  localparam logic [11:0] PRIO_MAX   = 12'd2560;
  // ceil(2^20 / 5): exact floor division by five below 2^18
  localparam logic [17:0] RECIP_FIVE = 18'd209716;

  typedef logic [15:0] deg_t;

  typedef struct packed {
    logic [15:0] bandwidth_mbps;
    logic [15:0] latency_ms;
    logic [15:0] throughput_ratio;
  } in_t;

  typedef struct packed {
    logic [11:0] priority_res;
    logic        no_rule_fired;
  } out_t;

  typedef struct packed {
    deg_t low;
    deg_t med;
    deg_t high;
  } strength_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // trapezoid on a Q8.8 value, breakpoints in whole units, edges 20 units wide
  function automatic deg_t trap_q88(logic [15:0] x, int unsigned a, int unsigned b,
                                    int unsigned c, int unsigned d);
    logic [16:0] xa;
    logic [16:0] av;
    logic [16:0] bv;
    logic [16:0] cv;
    logic [16:0] dv;
    logic [16:0] n;
    logic [17:0] p;
    logic [35:0] m;
    deg_t        r;
    xa = {1'b0, x};
    av = 17'(a * 256);
    bv = 17'(b * 256);
    cv = 17'(c * 256);
    dv = 17'(d * 256);
    r  = '0;
    n  = '0;
    if (xa >= bv && xa <= cv) begin
      r = DEG_ONE;
    end else if (xa > av && xa < bv) begin
      n = xa - av;
    end else if (xa > cv && xa < dv) begin
      n = dv - xa;
    end
    p = {n[12:0], 5'b0};
    m = p * RECIP_FIVE;
    if (n != '0) begin
      r = m[35:20];
    end
    return r;
  endfunction

  // trapezoid on throughput scaled by five, breakpoints in units of 16384
  function automatic deg_t trap_thr(logic [18:0] x, int unsigned a, int unsigned b,
                                    int unsigned c, int unsigned d);
    logic [18:0] av;
    logic [18:0] bv;
    logic [18:0] cv;
    logic [18:0] dv;
    logic [18:0] n;
    deg_t        r;
    av = 19'(a * 16384);
    bv = 19'(b * 16384);
    cv = 19'(c * 16384);
    dv = 19'(d * 16384);
    r  = '0;
    n  = '0;
    if (x >= bv && x <= cv) begin
      r = DEG_ONE;
    end else if (x > av && x < bv) begin
      n = x - av;
      r = {n[14:0], 1'b0};
    end else if (x > cv && x < dv) begin
      n = dv - x;
      r = {n[14:0], 1'b0};
    end
    return r;
  endfunction

  // output set membership at half step k
  function automatic deg_t out_mu(int unsigned set, int unsigned k);
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned d;
    deg_t        r;
    a = set * 8 - ((set != 0) ? 4 : 0);
    b = set * 8;
    c = set * 8 + 4;
    d = set * 8 + 8;
    if (set == 0) begin
      c = 4;
      d = 8;
    end
    if (set == 2) begin
      c = 20;
      d = 20;
    end
    r = '0;
    if (k >= b && k <= c) begin
      r = DEG_ONE;
    end else if (k > a && k < b) begin
      r = 16'((k - a) * 8192);
    end else if (k > c && k < d) begin
      r = 16'((d - k) * 8192);
    end
    return r;
  endfunction

  function automatic deg_t dmin(deg_t p, deg_t q);
    return (p < q) ? p : q;
  endfunction

  function automatic deg_t dmax(deg_t p, deg_t q);
    return (p > q) ? p : q;
  endfunction

endpackage

[src/fpc_front.sv]
// ----------------------------------------------------------------------------
// Fuzzy priority controller front end
// Accepts samples, fuzzifies them and evaluates the rule strengths.
// ----------------------------------------------------------------------------
module fpc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fpc_pkg::in_t        in_data_i,
  input  fpc_pkg::fifo_stat_t stat_i,
  output logic                push_o,
  output fpc_pkg::strength_t  push_data_o
);

  fpc_pkg::deg_t b_d [3];
  fpc_pkg::deg_t l_d [3];
  fpc_pkg::deg_t t_d [3];
  fpc_pkg::deg_t b_q [3];
  fpc_pkg::deg_t l_q [3];
  fpc_pkg::deg_t t_q [3];
  logic          vld_q;
  logic [18:0]   thr5;

  assign thr5 = {3'b0, in_data_i.throughput_ratio} * 19'd5;

  always_comb begin
    b_d[0] = fpc_pkg::trap_q88(in_data_i.bandwidth_mbps, 0, 0, 20, 40);
    b_d[1] = fpc_pkg::trap_q88(in_data_i.bandwidth_mbps, 20, 40, 60, 80);
    b_d[2] = fpc_pkg::trap_q88(in_data_i.bandwidth_mbps, 60, 80, 100, 100);
    l_d[0] = fpc_pkg::trap_q88(in_data_i.latency_ms, 0, 0, 10, 30);
    l_d[1] = fpc_pkg::trap_q88(in_data_i.latency_ms, 10, 30, 50, 70);
    l_d[2] = fpc_pkg::trap_q88(in_data_i.latency_ms, 50, 70, 100, 100);
    t_d[0] = fpc_pkg::trap_thr(thr5, 0, 0, 1, 2);
    t_d[1] = fpc_pkg::trap_thr(thr5, 1, 2, 3, 4);
    t_d[2] = fpc_pkg::trap_thr(thr5, 3, 4, 5, 5);
  end

  assign push_o     = vld_q && !stat_i.full;
  assign in_ready_o = !vld_q || push_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      b_q <= b_d;
      l_q <= l_d;
      t_q <= t_d;
    end
  end

  always_comb begin
    push_data_o.high = fpc_pkg::dmax(fpc_pkg::dmin(b_q[2], l_q[0]), t_q[2]);
    push_data_o.med  = fpc_pkg::dmax(b_q[1], t_q[1]);
    push_data_o.low  = fpc_pkg::dmax(fpc_pkg::dmax(l_q[2], t_q[0]),
                                     fpc_pkg::dmin(b_q[0], l_q[2]));
  end

endmodule

[src/fpc_fifo.sv]
// ----------------------------------------------------------------------------
// Fuzzy priority controller queue
// Small register queue of rule strengths between front and back end.
// ----------------------------------------------------------------------------
module fpc_fifo #(
  parameter int unsigned DEPTH = fpc_pkg::FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fpc_pkg::strength_t  push_data_i,
  input  logic                pop_i,
  output fpc_pkg::strength_t  pop_data_o,
  output fpc_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fpc_pkg::strength_t mem_q [DEPTH];
  logic [PW-1:0]      wptr_q;
  logic [PW-1:0]      rptr_q;
  logic [CW-1:0]      cnt_q;
  logic               do_push;
  logic               do_pop;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue count beyond depth");
`endif

endmodule

[src/fpc_back.sv]
// ----------------------------------------------------------------------------
// Fuzzy priority controller back end
// Clips the output sets, forms the centroid sums and divides them.
// ----------------------------------------------------------------------------
module fpc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpc_pkg::fifo_stat_t stat_i,
  input  fpc_pkg::strength_t  pop_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fpc_pkg::out_t       out_data_o
);

  localparam int unsigned NS = fpc_pkg::DIV_STEPS;

  typedef struct packed {
    logic [19:0] r;
    logic [11:0] lo;
    logic [11:0] q;
    logic [19:0] den;
    logic        zero;
  } div_t;

  logic          en;
  logic          v1_q;
  logic          v2_q;
  logic [NS:0]   vd_q;
  fpc_pkg::deg_t mu_d [fpc_pkg::OUT_POINTS];
  fpc_pkg::deg_t mu_q [fpc_pkg::OUT_POINTS];
  logic [22:0]   num_d;
  logic [19:0]   den_d;
  logic [22:0]   num_q;
  logic [19:0]   den_q;
  div_t          st_q [NS+1];
  div_t          st_d [NS+1];
  logic [20:0]   tmp  [NS+1];

  assign en          = !out_valid_o || out_ready_i;
  assign pop_o       = en && !stat_i.empty;
  assign out_valid_o = vd_q[NS];

  always_comb begin
    for (int k = 0; k < fpc_pkg::OUT_POINTS; k++) begin
      mu_d[k] = fpc_pkg::dmax(
                  fpc_pkg::dmax(fpc_pkg::dmin(pop_data_i.low, fpc_pkg::out_mu(0, k)),
                                fpc_pkg::dmin(pop_data_i.med, fpc_pkg::out_mu(1, k))),
                  fpc_pkg::dmin(pop_data_i.high, fpc_pkg::out_mu(2, k)));
    end
  end

  always_comb begin
    num_d = '0;
    den_d = '0;
    for (int k = 0; k < fpc_pkg::OUT_POINTS; k++) begin
      num_d = num_d + 23'(mu_q[k]) * 23'(k);
      den_d = den_d + 20'(mu_q[k]);
    end
  end

  always_comb begin
    st_d[0].r    = {2'b0, num_q[22:5]};
    st_d[0].lo   = {num_q[4:0], 7'b0};
    st_d[0].q    = '0;
    st_d[0].den  = den_q;
    st_d[0].zero = (den_q == '0);
    tmp[0]       = '0;
    for (int i = 1; i <= NS; i++) begin
      tmp[i]       = {st_q[i-1].r, st_q[i-1].lo[11]};
      st_d[i]      = st_q[i-1];
      st_d[i].lo   = {st_q[i-1].lo[10:0], 1'b0};
      if (tmp[i] >= {1'b0, st_q[i-1].den}) begin
        st_d[i].r = 20'(tmp[i] - {1'b0, st_q[i-1].den});
        st_d[i].q = {st_q[i-1].q[10:0], 1'b1};
      end else begin
        st_d[i].r = tmp[i][19:0];
        st_d[i].q = {st_q[i-1].q[10:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vd_q <= '0;
    end else if (en) begin
      v1_q <= !stat_i.empty;
      v2_q <= v1_q;
      vd_q <= {vd_q[NS-1:0], v2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mu_q  <= mu_d;
      num_q <= num_d;
      den_q <= den_d;
      st_q  <= st_d;
    end
  end

  assign out_data_o.no_rule_fired = st_q[NS].zero;
  assign out_data_o.priority_res  = st_q[NS].zero ? '0 : st_q[NS].q;

`ifndef ASSERT_OFF
  a_zero_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_rule_fired |-> out_data_o.priority_res == '0)
    else $error("priority set with no rule fired");
  a_prio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.priority_res <= fpc_pkg::PRIO_MAX)
    else $error("priority out of range");
`endif

endmodule

[src/fuzzy_priority_controller.sv]
// ----------------------------------------------------------------------------
// Fuzzy priority controller
// Mamdani inference over trapezoid sets with a 21-point discrete centroid.
// ----------------------------------------------------------------------------
// One sample enters per cycle and one result leaves per cycle when the output
// side keeps up. The fuzzify register loads at the input transfer edge, and
// the result becomes valid after one queue slot, the clip and sum stages, a
// divider load stage and a twelve-stage restoring divider that yields one
// quotient bit per stage. A four-entry queue lets the fuzzifier keep taking
// samples while the divider pipeline is held.
module fuzzy_priority_controller #(
  parameter int unsigned FIFO_DEPTH = fpc_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpc_pkg::out_t out_data_o
);

  fpc_pkg::fifo_stat_t stat;
  fpc_pkg::strength_t  push_data;
  fpc_pkg::strength_t  pop_data;
  logic                push;
  logic                pop;

  fpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .stat_i      (stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  fpc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (stat)
  );

  fpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.full |-> !push) else $error("transfer into full queue");
`endif

endmodule
